>>> design/mmt_pkg.sv
package mmt_pkg;

  // Sizing of the name table and the message store.
  localparam int SLOT_COUNT   = 16;
  localparam int THREAD_COUNT = 8;
  localparam int SLOT_AW      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int TID_AW       = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
  localparam int WORD_W       = 32;
  localparam int MSG_W        = 4 * WORD_W;

  // Operation codes.
  localparam logic [2:0] OP_REGISTER   = 3'd0;
  localparam logic [2:0] OP_UNREGISTER = 3'd1;
  localparam logic [2:0] OP_SEND       = 3'd2;
  localparam logic [2:0] OP_RECEIVE    = 3'd3;
  localparam logic [2:0] OP_CHECK      = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NO_LISTENER = 2'd1;
  localparam logic [1:0] ST_FULL        = 2'd2;
  localparam logic [1:0] ST_EMPTY       = 2'd3;

  // One request as taken from the input channel.
  typedef struct packed {
    logic [2:0]        op;
    logic [2:0]        thread_id;
    logic [WORD_W-1:0] listen_name;
    logic [WORD_W-1:0] source;
    logic [WORD_W-1:0] destination;
    logic [WORD_W-1:0] payload;
    logic [WORD_W-1:0] length;
  } req_t;

  // One response as handed to the result channel.
  typedef struct packed {
    logic [1:0]        status;
    logic              pending;
    logic [WORD_W-1:0] source;
    logic [WORD_W-1:0] destination;
    logic [WORD_W-1:0] payload;
    logic [WORD_W-1:0] length;
  } rsp_t;

endpackage

>>> design/mmt_ram.sv
module mmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

>>> design/mmt_engine.sv
module mmt_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  mmt_pkg::req_t req,
  input  logic          ack,
  output logic          idle,
  output logic          done,
  output mmt_pkg::rsp_t rsp
);

  localparam int TID_AW  = mmt_pkg::TID_AW;
  localparam int SLOT_AW = mmt_pkg::SLOT_AW;
  localparam int WORD_W  = mmt_pkg::WORD_W;

  localparam logic [TID_AW-1:0]  T_LAST = TID_AW'(mmt_pkg::THREAD_COUNT - 1);
  localparam logic [SLOT_AW-1:0] S_LAST = SLOT_AW'(mmt_pkg::SLOT_COUNT - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_OWN   = 3'd2;
  localparam logic [2:0] S_OWNW  = 3'd3;
  localparam logic [2:0] S_NSCAN = 3'd4;
  localparam logic [2:0] S_SSCAN = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                       state_r, state_nxt;
  mmt_pkg::req_t                    req_r;
  mmt_pkg::rsp_t                    rsp_r, rsp_nxt;
  logic [WORD_W-1:0]                own_r, own_nxt;
  logic [TID_AW-1:0]                n_cnt_r, n_cnt_nxt, n_lag_r, n_lag_nxt;
  logic [SLOT_AW-1:0]               s_cnt_r, s_cnt_nxt, s_lag_r, s_lag_nxt;
  logic                             iss_r, iss_nxt;
  logic                             lag_vld_r, lag_vld_nxt;
  logic [mmt_pkg::THREAD_COUNT-1:0] name_vld_r, name_vld_nxt;
  logic [mmt_pkg::SLOT_COUNT-1:0]   slot_vld_r, slot_vld_nxt;

  logic                     tid_ok;
  logic [TID_AW-1:0]        tid_idx;
  logic                     free_found;
  logic [SLOT_AW-1:0]       free_idx;
  logic [1:0]               miss_status;
  logic [WORD_W-1:0]        own_eff;

  logic                     nm_we, nm_re;
  logic [TID_AW-1:0]        nm_ra;
  logic [WORD_W-1:0]        nm_rd;
  logic                     sl_we, sl_re;
  logic [mmt_pkg::MSG_W-1:0] sl_wd, sl_rd;
  logic [WORD_W-1:0]        sl_dst;

  // Listener names, one word per thread; an entry without its valid bit reads as no name.
  mmt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (mmt_pkg::THREAD_COUNT)
  ) u_name_ram (
    .clk     (clk),
    .wr_en   (nm_we),
    .wr_addr (tid_idx),
    .wr_data (req_r.listen_name),
    .rd_en   (nm_re),
    .rd_addr (nm_ra),
    .rd_data (nm_rd)
  );

  // Message slots: source, destination, payload and length side by side.
  mmt_ram #(
    .WIDTH (mmt_pkg::MSG_W),
    .DEPTH (mmt_pkg::SLOT_COUNT)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (sl_we),
    .wr_addr (free_idx),
    .wr_data (sl_wd),
    .rd_en   (sl_re),
    .rd_addr (s_cnt_r),
    .rd_data (sl_rd)
  );

  assign sl_wd   = {req_r.source, req_r.destination, req_r.payload, req_r.length};
  assign sl_dst  = sl_rd[2*WORD_W +: WORD_W];
  assign tid_ok  = 32'(req_r.thread_id) < mmt_pkg::THREAD_COUNT;
  assign tid_idx = TID_AW'(req_r.thread_id);
  assign own_eff = (tid_ok && name_vld_r[tid_idx]) ? nm_rd : '0;

  // A receive that finds nothing reports empty; a check reports success with no pending flag.
  assign miss_status = (req_r.op == mmt_pkg::OP_RECEIVE) ? mmt_pkg::ST_EMPTY : mmt_pkg::ST_OK;

  // Lowest free slot, straight from the valid bits.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = mmt_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_vld_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_AW'(i);
      end
    end
  end

  // Sequencer: dispatch, then a pipelined name or slot scan for send, receive, check.
  always_comb begin
    state_nxt    = state_r;
    rsp_nxt      = rsp_r;
    own_nxt      = own_r;
    n_cnt_nxt    = n_cnt_r;
    s_cnt_nxt    = s_cnt_r;
    n_lag_nxt    = n_cnt_r;
    s_lag_nxt    = s_cnt_r;
    iss_nxt      = iss_r;
    lag_vld_nxt  = 1'b0;
    name_vld_nxt = name_vld_r;
    slot_vld_nxt = slot_vld_r;
    nm_we        = 1'b0;
    nm_re        = 1'b0;
    nm_ra        = n_cnt_r;
    sl_we        = 1'b0;
    sl_re        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        rsp_nxt        = '0;
        rsp_nxt.status = mmt_pkg::ST_OK;
        n_cnt_nxt      = '0;
        s_cnt_nxt      = '0;
        iss_nxt        = 1'b1;
        case (req_r.op)
          mmt_pkg::OP_REGISTER: begin
            if (tid_ok) begin
              nm_we                 = 1'b1;
              name_vld_nxt[tid_idx] = 1'b1;
            end
            state_nxt = S_DONE;
          end
          mmt_pkg::OP_UNREGISTER: begin
            if (tid_ok) begin
              name_vld_nxt[tid_idx] = 1'b0;
            end
            state_nxt = S_DONE;
          end
          mmt_pkg::OP_SEND: begin
            if (req_r.destination == '0) begin
              rsp_nxt.status = mmt_pkg::ST_NO_LISTENER;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_NSCAN;
            end
          end
          mmt_pkg::OP_RECEIVE, mmt_pkg::OP_CHECK: begin
            state_nxt = S_OWN;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      // Fetch the caller's own name.
      S_OWN: begin
        nm_re     = 1'b1;
        nm_ra     = tid_idx;
        state_nxt = S_OWNW;
      end

      S_OWNW: begin
        own_nxt = own_eff;
        if (own_eff == '0) begin
          rsp_nxt.status = miss_status;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_SSCAN;
        end
      end

      // Find a thread listening on the destination, then store the message if a slot is free.
      S_NSCAN: begin
        if (iss_r) begin
          nm_re       = 1'b1;
          lag_vld_nxt = 1'b1;
          if (n_cnt_r == T_LAST) begin
            iss_nxt = 1'b0;
          end else begin
            n_cnt_nxt = n_cnt_r + 1'b1;
          end
        end
        if (lag_vld_r && name_vld_r[n_lag_r] && nm_rd == req_r.destination) begin
          if (free_found) begin
            sl_we                  = 1'b1;
            slot_vld_nxt[free_idx] = 1'b1;
            rsp_nxt.status         = mmt_pkg::ST_OK;
          end else begin
            rsp_nxt.status = mmt_pkg::ST_FULL;
          end
          state_nxt = S_DONE;
        end else if (lag_vld_r && n_lag_r == T_LAST) begin
          rsp_nxt.status = mmt_pkg::ST_NO_LISTENER;
          state_nxt      = S_DONE;
        end
      end

      // Look for the lowest occupied slot addressed to the caller.
      S_SSCAN: begin
        if (iss_r) begin
          sl_re       = 1'b1;
          lag_vld_nxt = 1'b1;
          if (s_cnt_r == S_LAST) begin
            iss_nxt = 1'b0;
          end else begin
            s_cnt_nxt = s_cnt_r + 1'b1;
          end
        end
        if (lag_vld_r && slot_vld_r[s_lag_r] && sl_dst == own_r) begin
          rsp_nxt.status = mmt_pkg::ST_OK;
          if (req_r.op == mmt_pkg::OP_RECEIVE) begin
            rsp_nxt.source        = sl_rd[3*WORD_W +: WORD_W];
            rsp_nxt.destination   = sl_dst;
            rsp_nxt.payload       = sl_rd[WORD_W +: WORD_W];
            rsp_nxt.length        = sl_rd[0 +: WORD_W];
            slot_vld_nxt[s_lag_r] = 1'b0;
          end else begin
            rsp_nxt.pending = 1'b1;
          end
          state_nxt = S_DONE;
        end else if (lag_vld_r && s_lag_r == S_LAST) begin
          rsp_nxt.status = miss_status;
          state_nxt      = S_DONE;
        end
      end

      S_DONE: begin
        if (ack) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      iss_r      <= 1'b0;
      lag_vld_r  <= 1'b0;
      name_vld_r <= '0;
      slot_vld_r <= '0;
    end else begin
      state_r    <= state_nxt;
      iss_r      <= iss_nxt;
      lag_vld_r  <= lag_vld_nxt;
      name_vld_r <= name_vld_nxt;
      slot_vld_r <= slot_vld_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      req_r <= req;
    end
    rsp_r   <= rsp_nxt;
    own_r   <= own_nxt;
    n_cnt_r <= n_cnt_nxt;
    s_cnt_r <= s_cnt_nxt;
    n_lag_r <= n_lag_nxt;
    s_lag_r <= s_lag_nxt;
  end

  assign idle = (state_r == S_IDLE);
  assign done = (state_r == S_DONE);
  assign rsp  = rsp_r;

endmodule

>>> design/message_mailbox_table.sv
// Channel   Direction  Handshake           Beat contents
// in_       input      in_valid/in_stall   op, thread id, name, message to send
// out_      output     out_valid/out_stall status, pending flag, received message
//
// Register and unregister finish without a scan; a send runs a pipelined scan
// over the name memory and a receive or check one over the slot memory.
// The next input beat can be taken from the cycle in which out_valid rises.
// Reset is synchronous and clears every name and slot; no clearing pass follows.
// A result held by out_stall does not block the next input beat; that item
// waits at its end until the output register is free.
module message_mailbox_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [2:0]  in_thread_id,
  input  logic [31:0] in_listen_name,
  input  logic [31:0] in_source,
  input  logic [31:0] in_destination,
  input  logic [31:0] in_payload,
  input  logic [31:0] in_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_pending,
  output logic [31:0] out_source,
  output logic [31:0] out_destination,
  output logic [31:0] out_payload,
  output logic [31:0] out_length
);

  mmt_pkg::req_t in_req;
  mmt_pkg::rsp_t eng_rsp;
  mmt_pkg::rsp_t out_rsp_r;
  logic          out_valid_r, out_valid_nxt;
  logic          in_acc;
  logic          out_load;
  logic          eng_idle;
  logic          eng_done;

  // Gather the input beat.
  always_comb begin
    in_req.op          = in_op;
    in_req.thread_id   = in_thread_id;
    in_req.listen_name = in_listen_name;
    in_req.source      = in_source;
    in_req.destination = in_destination;
    in_req.payload     = in_payload;
    in_req.length      = in_length;
  end

  assign in_stall = !eng_idle;
  assign in_acc   = in_valid && !in_stall;
  assign out_load = eng_done && (!out_valid_r || !out_stall);

  mmt_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .req   (in_req),
    .ack   (out_load),
    .idle  (eng_idle),
    .done  (eng_done),
    .rsp   (eng_rsp)
  );

  // Output register: loads when empty or being drained.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rsp_r <= eng_rsp;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_rsp_r.status;
  assign out_pending     = out_rsp_r.pending;
  assign out_source      = out_rsp_r.source;
  assign out_destination = out_rsp_r.destination;
  assign out_payload     = out_rsp_r.payload;
  assign out_length      = out_rsp_r.length;

  // A new result only ever comes from a finished engine.
  a_out_from_engine : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(eng_done))
    else $error("result appeared without a finished operation");

  // The pending flag goes only with a successful check.
  a_pending_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pending |-> out_status == mmt_pkg::ST_OK)
    else $error("pending flag with a failing status");

  // A failed operation carries no message.
  a_fail_empty : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != mmt_pkg::ST_OK |->
      out_source == '0 && out_destination == '0 && out_payload == '0 && out_length == '0)
    else $error("message fields set on a failed operation");

  // Once a beat is taken the engine is busy in the next cycle.
  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("engine idle straight after accepting a beat");

endmodule
